@@ rtl/core/hqm_pkg.sv @@
// Shared types, constants and helper functions for the HSL qualifier matte.
// No dependencies; every other file of the block imports this package.
package hqm_pkg;

   localparam int FRAC_BITS = 15;
   localparam int VAL_W = 16;
   localparam logic [VAL_W-1:0] ONE = VAL_W'(1 << FRAC_BITS);

   // Restoring divider geometry: numerator and divisor up to 18 bits,
   // quotient of 16 bits, one quotient bit per stage.
   localparam int DIV_W = 18;
   localparam int DIV_Q_W = 16;
   localparam int DIV_STAGES = DIV_Q_W;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUE_WINDOW = 3'd0,
      CSR_SAT_WINDOW = 3'd1,
      CSR_LUM_WINDOW = 3'd2,
      CSR_BLACK_CLIP = 3'd3,
      CSR_WHITE_CLIP = 3'd4,
      CSR_INVERT     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MAX_RED   = 2'd0,
      MAX_GREEN = 2'd1,
      MAX_BLUE  = 2'd2
   } max_sel_type;

   typedef struct packed {
      logic [VAL_W-1:0] margin;
      logic [VAL_W-1:0] hi;
      logic [VAL_W-1:0] lo;
   } window_type;

   typedef struct packed {
      window_type       hue;
      window_type       sat;
      window_type       lum;
      logic [VAL_W-1:0] black;
      logic [VAL_W-1:0] white;
      logic             invert;
   } cfg_type;

   // Output of the colour-space front end, ready for the first divider bank.
   typedef struct packed {
      logic             valid;
      logic [DIV_W-1:0] sat_n;
      logic [DIV_W-1:0] sat_d;
      logic [DIV_W-1:0] hue_n;
      logic [DIV_W-1:0] hue_d;
      logic             hue_neg;
      logic             grey;
      logic [VAL_W-1:0] lum;
   } front_type;

   typedef struct packed {
      logic             in_band;
      logic             ramp;
      logic [DIV_W-1:0] span;
      logic [DIV_W-1:0] margin;
   } ramp_req_type;

   typedef struct packed {
      logic                   valid;
      ramp_req_type [3:0]     req;
   } ramp_stage_type;

   // Classifies a value against one window and returns the margin distance
   // that the ramp divider needs. The lower margin takes priority.
   function automatic ramp_req_type ramp_setup(input logic [VAL_W-1:0] v,
                                               input logic [VAL_W:0]   lo,
                                               input logic [VAL_W:0]   hi,
                                               input logic [VAL_W-1:0] margin);
      logic [DIV_W-1:0] v18;
      logic [DIV_W-1:0] lo18;
      logic [DIV_W-1:0] hi18;
      logic [DIV_W-1:0] s18;
      logic             below;
      logic             above;
      ramp_req_type     res;
      v18   = DIV_W'(v);
      lo18  = DIV_W'(lo);
      hi18  = DIV_W'(hi);
      s18   = DIV_W'(margin);
      below = (margin != '0) && (v18 < lo18) && ((v18 + s18) > lo18);
      above = (margin != '0) && (v18 > hi18) && (v18 < (hi18 + s18));
      res.in_band = (v18 >= lo18) && (v18 <= hi18);
      res.ramp    = !res.in_band && (below || above);
      res.span    = below ? (v18 + s18 - lo18) : (hi18 + s18 - v18);
      res.margin  = s18;
      return res;
   endfunction

endpackage

@@ rtl/core/hqm_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on hqm_pkg; the numerator must be below twice the divisor.
module hqm_div_pipe
   import hqm_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [DIV_W-1:0]   n_in,
   input  logic [DIV_W-1:0]   d_in,
   output logic [DIV_Q_W-1:0] q_out
);

   logic [DIV_W-1:0]   rem_ff [DIV_STAGES];
   logic [DIV_W-1:0]   d_ff   [DIV_STAGES];
   logic [DIV_Q_W-1:0] q_ff   [DIV_STAGES];

   // First stage decides the integer bit, which is 0 or 1 here.
   logic             bit0;
   logic [DIV_W-1:0] rem0_in;

   always_comb begin
      bit0    = (n_in >= d_in);
      rem0_in = bit0 ? (n_in - d_in) : n_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem0_in;
         d_ff[0]   <= d_in;
         q_ff[0]   <= DIV_Q_W'(bit0);
      end
   end

   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_W:0]   r2;
      logic             qb;
      logic [DIV_W-1:0] rem_in;

      always_comb begin
         r2     = {rem_ff[k-1], 1'b0};
         qb     = (r2 >= {1'b0, d_ff[k-1]});
         rem_in = qb ? DIV_W'(r2 - {1'b0, d_ff[k-1]}) : DIV_W'(r2);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            d_ff[k]   <= d_ff[k-1];
            q_ff[k]   <= {q_ff[k-1][DIV_Q_W-2:0], qb};
         end
      end
   end

   assign q_out = q_ff[DIV_STAGES-1];

endmodule

@@ rtl/core/hqm_hsl_front.sv @@
// Colour-space front end: clamps RGB, finds extremes and forms the
// saturation and hue division operands over three stages. Uses hqm_pkg.
module hqm_hsl_front
   import hqm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [VAL_W-1:0] red,
   input  logic [VAL_W-1:0] green,
   input  logic [VAL_W-1:0] blue,
   output front_type        front_out
);

   logic             v1_ff, v2_ff;
   logic [VAL_W-1:0] r1_ff, g1_ff, b1_ff;
   logic [VAL_W-1:0] r2_ff, g2_ff, b2_ff, mx2_ff, mn2_ff;
   max_sel_type      sel2_ff;
   front_type        front_ff;

   logic [VAL_W-1:0] mx_in, mn_in;
   max_sel_type      sel_in;
   front_type        front_in;
   logic [VAL_W-1:0] delta;
   logic [VAL_W:0]   sum;
   logic [VAL_W:0]   den;

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff   <= (red   > ONE) ? ONE : red;
         g1_ff   <= (green > ONE) ? ONE : green;
         b1_ff   <= (blue  > ONE) ? ONE : blue;
         r2_ff   <= r1_ff;
         g2_ff   <= g1_ff;
         b2_ff   <= b1_ff;
         mx2_ff  <= mx_in;
         mn2_ff  <= mn_in;
         sel2_ff <= sel_in;
         front_ff.sat_n   <= front_in.sat_n;
         front_ff.sat_d   <= front_in.sat_d;
         front_ff.hue_n   <= front_in.hue_n;
         front_ff.hue_d   <= front_in.hue_d;
         front_ff.hue_neg <= front_in.hue_neg;
         front_ff.grey    <= front_in.grey;
         front_ff.lum     <= front_in.lum;
      end
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         front_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff          <= in_valid;
         v2_ff          <= v1_ff;
         front_ff.valid <= v2_ff;
      end
   end

   // Red wins ties, then green.
   always_comb begin
      mx_in  = r1_ff;
      sel_in = MAX_RED;
      if (g1_ff > mx_in) begin
         mx_in  = g1_ff;
         sel_in = MAX_GREEN;
      end
      if (b1_ff > mx_in) begin
         mx_in  = b1_ff;
         sel_in = MAX_BLUE;
      end
      mn_in = r1_ff;
      if (g1_ff < mn_in) mn_in = g1_ff;
      if (b1_ff < mn_in) mn_in = b1_ff;
   end

   always_comb begin
      delta = mx2_ff - mn2_ff;
      sum   = {1'b0, mx2_ff} + {1'b0, mn2_ff};
      den   = (sum <= {1'b0, ONE}) ? sum : ({ONE, 1'b0} - sum);
      front_in         = '0;
      front_in.valid   = v2_ff;
      front_in.lum     = sum[VAL_W:1];
      front_in.grey    = (delta == '0);
      front_in.sat_n   = DIV_W'(delta);
      front_in.sat_d   = DIV_W'(den);
      front_in.hue_d   = DIV_W'(delta) * DIV_W'(6);
      case (sel2_ff)
         MAX_RED: begin
            front_in.hue_neg = (g2_ff < b2_ff);
            front_in.hue_n   = front_in.hue_neg ? DIV_W'(b2_ff - g2_ff)
                                                : DIV_W'(g2_ff - b2_ff);
         end
         MAX_GREEN: begin
            front_in.hue_n = DIV_W'(b2_ff) - DIV_W'(r2_ff) + (DIV_W'(delta) << 1);
         end
         MAX_BLUE: begin
            front_in.hue_n = DIV_W'(r2_ff) - DIV_W'(g2_ff) + (DIV_W'(delta) << 2);
         end
         default: begin
            front_in.hue_n = '0;
         end
      endcase
   end

   assign front_out = front_ff;

endmodule

@@ rtl/core/hqm_ramp_setup.sv @@
// Window classification stage: compares hue, saturation and luminance with
// their windows and forms the four margin divisions. Uses hqm_pkg.
module hqm_ramp_setup
   import hqm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [VAL_W-1:0] hue,
   input  logic [VAL_W-1:0] sat,
   input  logic [VAL_W-1:0] lum,
   input  cfg_type          cfg,
   output ramp_stage_type   ramp_out
);

   ramp_stage_type stage_ff;
   ramp_stage_type stage_in;
   logic           wrapped;

   always_comb begin
      wrapped        = (cfg.hue.lo > cfg.hue.hi);
      stage_in       = '0;
      stage_in.valid = in_valid;
      if (wrapped) begin
         // Wrapped hue: sub-windows [low, one] and [0, high].
         stage_in.req[0] = ramp_setup(hue, {1'b0, cfg.hue.lo}, {1'b0, ONE},
                                      cfg.hue.margin);
         stage_in.req[1] = ramp_setup(hue, '0, {1'b0, cfg.hue.hi}, cfg.hue.margin);
      end else begin
         stage_in.req[0] = ramp_setup(hue, {1'b0, cfg.hue.lo}, {1'b0, cfg.hue.hi},
                                      cfg.hue.margin);
      end
      stage_in.req[2] = ramp_setup(sat, {1'b0, cfg.sat.lo}, {1'b0, cfg.sat.hi},
                                   cfg.sat.margin);
      stage_in.req[3] = ramp_setup(lum, {1'b0, cfg.lum.lo}, {1'b0, cfg.lum.hi},
                                   cfg.lum.margin);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff.req <= stage_in.req;
      end
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   assign ramp_out = stage_ff;

endmodule

@@ rtl/core/hqm_matte_back.sv @@
// Back end: turns the ramp quotients into weights, multiplies them and
// applies the clean-black, clean-white and invert controls. Uses hqm_pkg.
module hqm_matte_back
   import hqm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [3:0]               in_band,
   input  logic [3:0]               ramp,
   input  logic [3:0][DIV_Q_W-1:0]  quot,
   input  cfg_type                  cfg,
   output logic                     out_valid,
   output logic [VAL_W-1:0]         matte
);

   logic             v6_ff, v7_ff, v8_ff, v9_ff;
   logic [VAL_W-1:0] hw_ff, sw_ff, lw_ff, lw7_ff;
   logic [VAL_W-1:0] p1_ff, p2_ff, matte_ff;

   logic [3:0][VAL_W-1:0] w;
   logic [2*VAL_W-1:0]    m1, m2;
   logic [VAL_W:0]        white_sum;
   logic [VAL_W-1:0]      snap, matte_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         w[i] = in_band[i] ? ONE : (ramp[i] ? VAL_W'(quot[i]) : '0);
      end
      m1 = hw_ff * sw_ff;
      m2 = p1_ff * lw7_ff;
   end

   always_comb begin
      snap = p2_ff;
      if (p2_ff <= cfg.black) snap = '0;
      white_sum = {1'b0, snap} + {1'b0, cfg.white};
      if (white_sum >= {1'b0, ONE}) snap = ONE;
      matte_in = cfg.invert ? (ONE - snap) : snap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= in_valid;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hw_ff    <= (w[0] > w[1]) ? w[0] : w[1];
         sw_ff    <= w[2];
         lw_ff    <= w[3];
         p1_ff    <= m1[FRAC_BITS +: VAL_W];
         lw7_ff   <= lw_ff;
         p2_ff    <= m2[FRAC_BITS +: VAL_W];
         matte_ff <= matte_in;
      end
   end

   assign out_valid = v9_ff;
   assign matte     = matte_ff;

endmodule

@@ rtl/core/hsl_qualifier_matte_top.sv @@
// HSL qualifier matte: top level with the register file, divider banks and
// the stage wiring. Depends on hqm_pkg and all hqm_ submodules.
//
// The block accepts one RGB pixel every clock cycle and returns one matte
// value per pixel, in order, through these stages: three stages of colour-space
// front end, a 16-stage divider bank for saturation and hue, one stage that
// settles hue and saturation, one stage of window classification, a second
// 16-stage divider bank for the four softness ramps, and four stages for the
// weights, the two products and the clip and invert controls. The whole
// pipeline advances together; it holds only when a result waits at the
// output and the receiver stalls, and then req_stall rises in the same cycle.
// Configuration writes are always taken (csr_ready stays high) and should
// only be made while no pixel is in flight.
module hsl_qualifier_matte_top
   import hqm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VAL_W-1:0]      req_red,
   input  logic [VAL_W-1:0]      req_green,
   input  logic [VAL_W-1:0]      req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VAL_W-1:0]      rsp_matte,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] lum;
      logic             hue_neg;
      logic             grey;
   } band1_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] in_band;
      logic [3:0] ramp;
   } band2_type;

   cfg_type cfg_ff;
   logic    en;

   // Configuration registers. A transfer to an index beyond the list is dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue    <= '{margin: '0, hi: ONE, lo: '0};
         cfg_ff.sat    <= '{margin: '0, hi: ONE, lo: '0};
         cfg_ff.lum    <= '{margin: '0, hi: ONE, lo: '0};
         cfg_ff.black  <= '0;
         cfg_ff.white  <= '0;
         cfg_ff.invert <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HUE_WINDOW: cfg_ff.hue    <= csr_wdata;
            CSR_SAT_WINDOW: cfg_ff.sat    <= csr_wdata;
            CSR_LUM_WINDOW: cfg_ff.lum    <= csr_wdata;
            CSR_BLACK_CLIP: cfg_ff.black  <= csr_wdata[VAL_W-1:0];
            CSR_WHITE_CLIP: cfg_ff.white  <= csr_wdata[VAL_W-1:0];
            CSR_INVERT:     cfg_ff.invert <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Every stage moves unless a finished result is held by the receiver.
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // Front end and first divider bank.
   front_type front;
   logic [DIV_Q_W-1:0] sat_q, hue_q;

   hqm_hsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .front_out (front)
   );

   hqm_div_pipe u_div_sat (
      .clock (clock), .en (en), .n_in (front.sat_n), .d_in (front.sat_d), .q_out (sat_q)
   );

   hqm_div_pipe u_div_hue (
      .clock (clock), .en (en), .n_in (front.hue_n), .d_in (front.hue_d), .q_out (hue_q)
   );

   // Side band that travels alongside the first divider bank.
   band1_type band1_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         band1_ff[0].lum     <= front.lum;
         band1_ff[0].hue_neg <= front.hue_neg;
         band1_ff[0].grey    <= front.grey;
         for (int i = 1; i < DIV_STAGES; i++) begin
            band1_ff[i].lum     <= band1_ff[i-1].lum;
            band1_ff[i].hue_neg <= band1_ff[i-1].hue_neg;
            band1_ff[i].grey    <= band1_ff[i-1].grey;
         end
      end
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) band1_ff[i].valid <= 1'b0;
      end else if (en) begin
         band1_ff[0].valid <= front.valid;
         for (int i = 1; i < DIV_STAGES; i++) band1_ff[i].valid <= band1_ff[i-1].valid;
      end
   end

   // Settle hue and saturation. A negative red-sector hue is taken from one,
   // and a hue of exactly one wraps to zero; grey pixels have no hue or
   // saturation.
   logic             v4_ff;
   logic [VAL_W-1:0] h4_ff, s4_ff, l4_ff;
   logic [VAL_W-1:0] h4_in, s4_in;
   band1_type        b1_last;

   assign b1_last = band1_ff[DIV_STAGES-1];

   always_comb begin
      h4_in = VAL_W'(hue_q);
      if (b1_last.hue_neg) begin
         h4_in = (hue_q == '0) ? '0 : (ONE - VAL_W'(hue_q));
      end
      s4_in = VAL_W'(sat_q);
      if (b1_last.grey) begin
         h4_in = '0;
         s4_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= b1_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h4_ff <= h4_in;
         s4_ff <= s4_in;
         l4_ff <= b1_last.lum;
      end
   end

   // Window classification and the second divider bank, one divider for
   // each of the two hue sub-windows, saturation and luminance.
   ramp_stage_type        rstage;
   logic [3:0][DIV_Q_W-1:0] ramp_q;

   hqm_ramp_setup u_ramp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v4_ff),
      .hue      (h4_ff),
      .sat      (s4_ff),
      .lum      (l4_ff),
      .cfg      (cfg_ff),
      .ramp_out (rstage)
   );

   for (genvar k = 0; k < 4; k++) begin : g_ramp_div
      hqm_div_pipe u_div (
         .clock (clock),
         .en    (en),
         .n_in  (rstage.req[k].span),
         .d_in  (rstage.req[k].margin),
         .q_out (ramp_q[k])
      );
   end

   band2_type band2_ff [DIV_STAGES];
   band2_type band2_in;

   always_comb begin
      band2_in.valid = rstage.valid;
      for (int k = 0; k < 4; k++) begin
         band2_in.in_band[k] = rstage.req[k].in_band;
         band2_in.ramp[k]    = rstage.req[k].ramp;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         band2_ff[0].in_band <= band2_in.in_band;
         band2_ff[0].ramp    <= band2_in.ramp;
         for (int i = 1; i < DIV_STAGES; i++) begin
            band2_ff[i].in_band <= band2_ff[i-1].in_band;
            band2_ff[i].ramp    <= band2_ff[i-1].ramp;
         end
      end
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) band2_ff[i].valid <= 1'b0;
      end else if (en) begin
         band2_ff[0].valid <= band2_in.valid;
         for (int i = 1; i < DIV_STAGES; i++) band2_ff[i].valid <= band2_ff[i-1].valid;
      end
   end

   // Weights, products and the output register.
   hqm_matte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (band2_ff[DIV_STAGES-1].valid),
      .in_band   (band2_ff[DIV_STAGES-1].in_band),
      .ramp      (band2_ff[DIV_STAGES-1].ramp),
      .quot      (ramp_q),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .matte     (rsp_matte)
   );

endmodule

@@ rtl/core/hqm_port_checker.sv @@
// Port-level checker for the HSL qualifier matte, bound to the top level.
// Depends on hqm_pkg for widths and the unit value.
module hqm_port_checker
   import hqm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [VAL_W-1:0] rsp_matte,
   input logic             csr_ready
);

   // The input side is held back only by a result that the receiver stalls.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // A matte never exceeds one.
   a_matte_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_matte <= ONE))
      else $error("matte above one");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_matte)))
      else $error("stalled result changed");

   // Nothing leaves the block in the first cycle after reset is released.
   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && csr_ready))
      else $error("result presented straight after reset");

endmodule

bind hsl_qualifier_matte_top hqm_port_checker u_hqm_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_matte (rsp_matte),
   .csr_ready (csr_ready)
);
